[design/recency_window_tracker_unit_assert.svh]
// ----------------------------------------------------------------------------
// recency window tracker assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RECENCY_WINDOW_TRACKER_UNIT_ASSERT_SVH
`define RECENCY_WINDOW_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RWT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RWT_CHECK(lbl, prop, msg) `RWT_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define RWT_ASSERT(lbl, clk, rstn, prop, msg)
`define RWT_CHECK(lbl, prop, msg)
`endif
`endif

[design/rwt_pkg.sv]
// ----------------------------------------------------------------------------
// rwt_pkg
// shared codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rwt_pkg;

  typedef enum logic [2:0] {
    OP_UPDATE      = 3'd0,
    OP_LIST_SPAN   = 3'd1,
    OP_LIST_PERIOD = 3'd2,
    OP_DRAIN       = 3'd3,
    OP_CLEAR       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_EVICT   = 2'd0,
    KIND_WINDOW  = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_SLOT = 2'd1,
    RD_TAIL = 2'd2,
    RD_NODE = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    latch;
    logic    scan_start;
    logic    scan_step;
    logic    slot_take;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    stamp_wr;
    logic    det;
    logic    push;
    logic    ins;
    logic    rm_tail;
    logic    rep;
    kind_e   rep_kind;
    logic    list_init;
    logic    list_adv;
    logic    clear;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic hit;
    logic scan_end;
    logic head_is_slot;
    logic count_zero;
    logic full;
    logic over_cap;
    logic list_end;
    logic list_pass;
    logic drain_pass;
    logic rep_ok;
    logic fin_ok;
  } status_t;

endpackage

[design/recency_window_tracker_unit.sv]
// ----------------------------------------------------------------------------
// recency_window_tracker_unit
// most-recently-updated key list with capacity eviction and time window
// listing and expiry
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// in       in   in_valid_i/in_ready_o   operation_i key_i stamp_i span_i
// out      out  out_valid_o/out_ready_i kind_o result_key_o last_o
// cfg      in   psel/penable/pready     paddr pwrite pwdata prdata
//
// sequence from input transfer to ready again with the output free, one item at a time
// update: key scan over all ENTRIES slots plus relink, with a tail eviction first
// when storage is full and one more tail eviction per capacity eviction
// listing: reports entries from the head until the list ends or one falls out of window
// drain: reports expired tail entries until the tail is kept or the list is empty; clear
// empties the list; reset empties the list; a held result stalls the walk at the next report
// ----------------------------------------------------------------------------
module recency_window_tracker_unit import rwt_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] key_i,
  input  logic [31:0] stamp_i,
  input  logic [31:0] span_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] result_key_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]  cap_q;
  logic [31:0] period_q;
  logic        cfg_wr;
  cmd_t        cmd;
  status_t     sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? period_q : {27'd0, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= 5'd16;
      period_q <= 32'd1000;
    end else if (cfg_wr) begin
      if (paddr[2]) period_q <= pwdata;
      else cap_q <= pwdata[4:0];
    end
  end

  rwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .stamp_i      (stamp_i),
    .span_i       (span_i),
    .cap_i        (cap_q),
    .period_i     (period_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .result_key_o (result_key_o),
    .last_o       (last_o)
  );

endmodule

[design/rwt_ctrl.sv]
// ----------------------------------------------------------------------------
// rwt_ctrl
// sequencer for update, listing, drain and clear
// ----------------------------------------------------------------------------
module rwt_ctrl import rwt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISPATCH = 14'b00000000000010,
    S_SCAN     = 14'b00000000000100,
    S_HIT_RD   = 14'b00000000001000,
    S_HIT_DET  = 14'b00000000010000,
    S_PUSH     = 14'b00000000100000,
    S_MISS     = 14'b00000001000000,
    S_INSERT   = 14'b00000010000000,
    S_TRIM     = 14'b00000100000000,
    S_DRAIN    = 14'b00001000000000,
    S_TAIL_RD  = 14'b00010000000000,
    S_TAIL_EV  = 14'b00100000000000,
    S_LIST_RD  = 14'b01000000000000,
    S_LIST_CHK = 14'b10000000000000
  } state_e;

  typedef enum logic [1:0] {
    M_FULL  = 2'd0,
    M_TRIM  = 2'd1,
    M_DRAIN = 2'd2
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   fin_q, fin_d;

  assign in_ready_o = (state_q == S_IDLE) && !fin_q;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    fin_d   = 1'b0;
    cmd_o   = '0;
    cmd_o.rd_sel   = RD_SCAN;
    cmd_o.rep_kind = KIND_EVICT;
    if (fin_q) begin
      cmd_o.finish = sts_i.fin_ok;
      fin_d        = !sts_i.fin_ok;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.latch = 1'b1;
            state_d     = S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (sts_i.op)
            OP_UPDATE: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
            OP_LIST_SPAN, OP_LIST_PERIOD: begin
              cmd_o.list_init = 1'b1;
              state_d         = S_LIST_RD;
            end
            OP_DRAIN: begin
              mode_d  = M_DRAIN;
              state_d = S_DRAIN;
            end
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              fin_d       = 1'b1;
              state_d     = S_IDLE;
            end
            default: begin
              fin_d   = 1'b1;
              state_d = S_IDLE;
            end
          endcase
        end
        S_SCAN: begin
          cmd_o.scan_step = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_SCAN;
          if (sts_i.hit) begin
            cmd_o.slot_take = 1'b1;
            state_d         = S_HIT_RD;
          end else if (sts_i.scan_end) begin
            state_d = S_MISS;
          end
        end
        S_HIT_RD: begin
          cmd_o.stamp_wr = 1'b1;
          if (sts_i.head_is_slot) begin
            state_d = S_TRIM;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_SLOT;
            state_d      = S_HIT_DET;
          end
        end
        S_HIT_DET: begin
          cmd_o.det = 1'b1;
          state_d   = S_PUSH;
        end
        S_PUSH: begin
          cmd_o.push = 1'b1;
          state_d    = S_TRIM;
        end
        S_MISS: begin
          if (sts_i.full) begin
            mode_d  = M_FULL;
            state_d = S_TAIL_RD;
          end else begin
            state_d = S_INSERT;
          end
        end
        S_INSERT: begin
          cmd_o.ins = 1'b1;
          state_d   = S_PUSH;
        end
        S_TRIM: begin
          if (sts_i.over_cap) begin
            mode_d  = M_TRIM;
            state_d = S_TAIL_RD;
          end else begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end
        end
        S_DRAIN: begin
          if (sts_i.count_zero) begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_TAIL_RD;
          end
        end
        S_TAIL_RD: begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_TAIL;
          state_d      = S_TAIL_EV;
        end
        S_TAIL_EV: begin
          if (mode_q == M_DRAIN && !sts_i.drain_pass) begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end else if (sts_i.rep_ok) begin
            cmd_o.rep      = 1'b1;
            cmd_o.rm_tail  = 1'b1;
            cmd_o.rep_kind = (mode_q == M_DRAIN) ? KIND_EXPIRED : KIND_EVICT;
            case (mode_q)
              M_FULL:  state_d = S_INSERT;
              M_TRIM:  state_d = S_TRIM;
              default: state_d = S_DRAIN;
            endcase
          end
        end
        S_LIST_RD: begin
          if (sts_i.list_end) begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_NODE;
            state_d      = S_LIST_CHK;
          end
        end
        S_LIST_CHK: begin
          if (!sts_i.list_pass) begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end else if (sts_i.rep_ok) begin
            cmd_o.rep      = 1'b1;
            cmd_o.rep_kind = KIND_WINDOW;
            cmd_o.list_adv = 1'b1;
            state_d        = S_LIST_RD;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_TRIM;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      fin_q   <= fin_d;
    end
  end

endmodule

[design/rwt_datapath.sv]
// ----------------------------------------------------------------------------
// rwt_datapath
// entry memories, linked list pointers, scan and output registers
// ----------------------------------------------------------------------------
module rwt_datapath import rwt_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output status_t      sts_o,
  input  logic [2:0]   operation_i,
  input  logic [31:0]  key_i,
  input  logic [31:0]  stamp_i,
  input  logic [31:0]  span_i,
  input  logic [4:0]   cap_i,
  input  logic [31:0]  period_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   kind_o,
  output logic [31:0]  result_key_o,
  output logic         last_o
);

  `include "recency_window_tracker_unit_assert.svh"

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CAPW = (CW > 5) ? CW : 5;

  logic [31:0]   key_mem   [ENTRIES];
  logic [31:0]   stamp_mem [ENTRIES];
  logic [IW-1:0] next_mem  [ENTRIES];
  logic [IW-1:0] prev_mem  [ENTRIES];

  logic [31:0]   key_rd_q, stamp_rd_q;
  logic [IW-1:0] next_rd_q, prev_rd_q;

  op_e           op_q;
  logic [31:0]   key_q, stamp_q, span_q, hstamp_q;
  logic [IW-1:0] head_q, tail_q, slot_q, node_q, cmp_idx_q, raddr, free_idx;
  logic [CW-1:0] count_q, list_i_q;
  logic [ENTRIES-1:0] valid_q;
  logic [IW:0]   scan_idx_q;
  logic          cmp_v_q;

  logic          pend_v_q;
  kind_e         pend_kind_q;
  logic [31:0]   pend_key_q;

  logic          out_valid_q, out_last_q;
  kind_e         out_kind_q;
  logic [31:0]   out_key_q;
  logic          out_free, out_load;

  logic [CAPW-1:0] capw, cap_eff;
  logic [31:0]     limit;
  logic [32:0]     list_sum, drain_sum;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SCAN: raddr = scan_idx_q[IW-1:0];
      RD_SLOT: raddr = slot_q;
      RD_TAIL: raddr = tail_q;
      RD_NODE: raddr = node_q;
      default: raddr = slot_q;
    endcase
  end

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    capw = CAPW'(cap_i);
    if (capw == '0) cap_eff = CAPW'(1);
    else if (capw > CAPW'(ENTRIES)) cap_eff = CAPW'(ENTRIES);
    else cap_eff = capw;
  end

  assign limit     = (op_q == OP_LIST_SPAN) ? span_q : period_i;
  assign list_sum  = {1'b0, stamp_rd_q} + {1'b0, limit};
  assign drain_sum = {1'b0, stamp_rd_q} + {1'b0, period_i};

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (cmd_i.rep && pend_v_q) || cmd_i.finish;

  always_comb begin
    sts_o.op           = op_q;
    sts_o.hit          = cmp_v_q && valid_q[cmp_idx_q] && (key_rd_q == key_q);
    sts_o.scan_end     = cmp_v_q && (cmp_idx_q == IW'(ENTRIES - 1));
    sts_o.head_is_slot = (head_q == slot_q);
    sts_o.count_zero   = (count_q == '0);
    sts_o.full         = (count_q == CW'(ENTRIES));
    sts_o.over_cap     = (CAPW'(count_q) > cap_eff);
    sts_o.list_end     = (list_i_q == count_q);
    sts_o.list_pass    = ({1'b0, hstamp_q} < list_sum);
    sts_o.drain_pass   = ({1'b0, hstamp_q} > drain_sum);
    sts_o.rep_ok       = !pend_v_q || out_free;
    sts_o.fin_ok       = out_free;
  end

  // entry memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      key_rd_q   <= key_mem[raddr];
      stamp_rd_q <= stamp_mem[raddr];
      next_rd_q  <= next_mem[raddr];
      prev_rd_q  <= prev_mem[raddr];
    end
    if (cmd_i.ins) key_mem[free_idx] <= key_q;
    if (cmd_i.ins) stamp_mem[free_idx] <= stamp_q;
    else if (cmd_i.stamp_wr) stamp_mem[slot_q] <= stamp_q;
    if (cmd_i.det) next_mem[prev_rd_q] <= next_rd_q;
    else if (cmd_i.push && count_q != '0) next_mem[slot_q] <= head_q;
    if (cmd_i.det && slot_q != tail_q) prev_mem[next_rd_q] <= prev_rd_q;
    else if (cmd_i.push && count_q != '0) prev_mem[head_q] <= slot_q;
  end

  // item, walk and pending payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_e'(operation_i);
      key_q   <= key_i;
      stamp_q <= stamp_i;
      span_q  <= span_i;
    end
    if (cmd_i.slot_take) slot_q <= cmp_idx_q;
    else if (cmd_i.ins) slot_q <= free_idx;
    if (cmd_i.stamp_wr || cmd_i.ins) hstamp_q <= stamp_q;
    if (cmd_i.list_init) begin
      node_q   <= head_q;
      list_i_q <= '0;
    end else if (cmd_i.list_adv) begin
      node_q   <= next_rd_q;
      list_i_q <= list_i_q + CW'(1);
    end
    if (cmd_i.scan_step) cmp_idx_q <= scan_idx_q[IW-1:0];
    if (cmd_i.rep) begin
      pend_kind_q <= cmd_i.rep_kind;
      pend_key_q  <= key_rd_q;
    end
    if (out_load) begin
      out_last_q <= cmd_i.finish;
      if (cmd_i.finish && !pend_v_q) begin
        out_kind_q <= KIND_NONE;
        out_key_q  <= '0;
      end else begin
        out_kind_q <= pend_kind_q;
        out_key_q  <= pend_key_q;
      end
    end
  end

  // list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      valid_q     <= '0;
      scan_idx_q  <= '0;
      cmp_v_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        cmp_v_q    <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_v_q    <= (scan_idx_q < (IW + 1)'(ENTRIES));
        scan_idx_q <= scan_idx_q + (IW + 1)'(1);
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end else if (cmd_i.det) begin
        if (slot_q == tail_q) tail_q <= prev_rd_q;
        count_q <= count_q - CW'(1);
      end else if (cmd_i.push) begin
        valid_q[slot_q] <= 1'b1;
        head_q          <= slot_q;
        if (count_q == '0) tail_q <= slot_q;
        count_q <= count_q + CW'(1);
      end else if (cmd_i.rm_tail) begin
        valid_q[tail_q] <= 1'b0;
        if (count_q > CW'(1)) tail_q <= prev_rd_q;
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.rep) pend_v_q <= 1'b1;
      else if (cmd_i.finish) pend_v_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign result_key_o = out_key_q;
  assign last_o       = out_last_q;

  `RWT_CHECK(a_count_range, count_q <= CW'(ENTRIES), "entry count above depth")
  `RWT_CHECK(a_empty_clean, (count_q == '0) |-> (valid_q == '0), "empty list with valid slot")
  `RWT_CHECK(a_no_overwrite, out_load |-> out_free, "result overwritten before transfer")

endmodule
